// ===== rtl/lts_pkg.sv =====
// lts_pkg: shared constants, codes and word types of the tournament selector
// no dependencies; every other file of the block but lts_ram imports it

package lts_pkg;

  localparam int POP_MAX    = 256;
  localparam int ROUNDS_MAX = 16;
  localparam int QDEPTH     = 2;

  localparam int IDX_W   = $clog2(POP_MAX);
  localparam int POP_W   = $clog2(POP_MAX + 1);
  localparam int RND_W   = $clog2(ROUNDS_MAX + 1);
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int CMD_W      = 2;
  localparam int ENTRY_W    = 8;
  localparam int FIT_W      = 32;
  localparam int SEED_W     = 32;
  localparam int WIN_W      = 8;
  localparam int POP_CFG_W  = 9;
  localparam int RND_CFG_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_ADD   = 32'd1013904223;
  localparam logic [31:0] RNG_RESET = 32'd12345;
  localparam logic [FIT_W-1:0] MINUS_INF = {1'b1, {(FIT_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_RESEED = 2'd1,
    CMD_TOUR   = 2'd2
  } lts_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POP_COUNT = 2'd0,
    CFG_ROUNDS    = 2'd1
  } lts_cfg_idx_e;

  typedef enum logic [1:0] {
    K_LOAD,
    K_RESEED,
    K_TOUR
  } lts_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } lts_state_t;

  typedef struct packed {
    lts_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       data;
  } lts_op_t;

  typedef struct packed {
    logic    valid;
    lts_op_t op;
  } lts_push_t;

  typedef struct packed {
    logic              full;
    logic              empty;
  } lts_qstat_t;

  typedef struct packed {
    logic [POP_W-1:0] n;
    logic [RND_W-1:0] r;
  } lts_cfgv_t;

  typedef struct packed {
    lts_state_t       state;
    logic [RND_W-1:0] cnt;
  } lts_back_stat_t;

endpackage

// ===== rtl/lts_ifs.sv =====
// lts_ifs: valid/ready channel interfaces for input words, result words and config writes
// depends on lts_pkg

interface lts_in_if import lts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [ENTRY_W-1:0]       entry_index;
  logic signed [FIT_W-1:0]  fitness_value;
  logic [SEED_W-1:0]        seed_value;

  modport source (output valid, command, entry_index, fitness_value, seed_value,
                  input ready);
  modport sink   (input valid, command, entry_index, fitness_value, seed_value,
                  output ready);
endinterface

interface lts_out_if import lts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [WIN_W-1:0]         winner_index;
  logic signed [FIT_W-1:0]  winner_fitness;
  logic                     found;

  modport source (output valid, winner_index, winner_fitness, found, input ready);
  modport sink   (input valid, winner_index, winner_fitness, found, output ready);
endinterface

interface lts_cfg_if import lts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lcg_tournament_selector_top.sv =====
// lcg_tournament_selector_top: top level, config registers and the front/queue/back chain
// depends on lts_pkg, lts_ifs, lts_front, lts_queue and lts_back

// Input words are decoded by the front and pass through a two-word queue to the back,
// which owns the fitness table, the generator and a one-word result register, so new
// words are taken while a tournament runs or a result waits. In the back a load or a
// reseed is done from the idle state; a tournament runs its rounds through the draw
// pipeline of generator step, population scaling multiply, registered table read and
// compare, which issues one draw a cycle. A result is shown as soon as the result
// register is free. Config writes are taken at any cycle and apply to every tournament
// the back starts afterwards, queued ones included, so write them only while no word
// is in flight; the table needs no clearing pass.

module lcg_tournament_selector_top import lts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lts_in_if.sink    in_ch,
  lts_out_if.source out_ch,
  lts_cfg_if.sink   cfg_ch
);

  logic [POP_CFG_W-1:0] pop_count_r, pop_count_nxt;
  logic [RND_CFG_W-1:0] rounds_r, rounds_nxt;
  lts_cfgv_t            cfgv;
  lts_push_t            q_push;
  lts_op_t              q_head;
  lts_qstat_t           q_stat;
  logic                 q_pop;
  lts_back_stat_t       b_stat;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    pop_count_nxt = pop_count_r;
    rounds_nxt    = rounds_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_POP_COUNT: pop_count_nxt = POP_CFG_W'(cfg_ch.data);
        CFG_ROUNDS:    rounds_nxt    = RND_CFG_W'(cfg_ch.data);
        default: begin
          pop_count_nxt = pop_count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_count_r <= POP_CFG_W'(256);
      rounds_r    <= RND_CFG_W'(3);
    end else begin
      pop_count_r <= pop_count_nxt;
      rounds_r    <= rounds_nxt;
    end
  end

  // saturate to the table size and the round limit
  assign cfgv.n = (32'(pop_count_r) > POP_MAX) ? POP_W'(POP_MAX) : POP_W'(pop_count_r);
  assign cfgv.r = (32'(rounds_r) > ROUNDS_MAX) ? RND_W'(ROUNDS_MAX) : RND_W'(rounds_r);

  lts_front u_front (
    .in_ch  (in_ch),
    .q_full (q_stat.full),
    .push   (q_push)
  );

  lts_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  lts_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfgv),
    .head   (q_head),
    .qstat  (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch),
    .stat   (b_stat)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> !q_stat.full)
    else $error("operation pushed into a full queue");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(b_stat.state == ST_DONE))
    else $error("result word raised outside a finished tournament");

  a_run_has_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (b_stat.state == ST_RUN) |-> (b_stat.cnt != '0))
    else $error("draw loop running with no rounds left");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_stat.empty) |=> (b_stat.state == ST_IDLE || b_stat.state == ST_RUN ||
                                  b_stat.state == ST_DONE))
    else $error("queue popped into drain state");

endmodule

// ===== rtl/lts_ram.sv =====
// lts_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module lts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lts_front.sv =====
// lts_front: accepts input words, decodes the command and forms queue operations
// depends on lts_pkg and lts_ifs

module lts_front import lts_pkg::*; (
  lts_in_if.sink     in_ch,
  input  logic       q_full,
  output lts_push_t  push
);

  logic accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    push.valid   = 1'b0;
    push.op.kind = K_TOUR;
    push.op.idx  = IDX_W'(in_ch.entry_index);
    push.op.data = in_ch.fitness_value;
    unique case (in_ch.command)
      CMD_LOAD: begin
        // slots beyond the table are dropped
        push.valid = accept && (32'(in_ch.entry_index) < POP_MAX);
        push.op.kind = K_LOAD;
      end
      CMD_RESEED: begin
        push.valid   = accept;
        push.op.kind = K_RESEED;
        push.op.data = in_ch.seed_value;
      end
      CMD_TOUR: begin
        push.valid   = accept;
        push.op.kind = K_TOUR;
      end
      default: begin
        push.valid = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/lts_queue.sv =====
// lts_queue: short fifo of decoded operations between front and back
// depends on lts_pkg

module lts_queue import lts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lts_push_t  push,
  input  logic       pop,
  output lts_op_t    head,
  output lts_qstat_t stat
);

  lts_op_t            entry_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (32'(p) == QDEPTH - 1) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  assign stat.full  = (32'(cnt_r) == QDEPTH);
  assign stat.empty = (cnt_r == '0);
  assign head       = entry_r[rptr_r];

  assign do_push = push.valid && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_comb begin
    wptr_nxt = do_push ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt = do_pop  ? ptr_inc(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r;
    priority if (do_push && !do_pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push.op;
    end
  end

endmodule

// ===== rtl/lts_back.sv =====
// lts_back: executes queued operations: table loads, reseeds and tournament draws
// depends on lts_pkg, lts_ifs and lts_ram

module lts_back import lts_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  lts_cfgv_t       cfg,
  input  lts_op_t         head,
  input  lts_qstat_t      qstat,
  output logic            pop,
  lts_out_if.source       out_ch,
  output lts_back_stat_t  stat
);

  lts_state_t             state_r, state_nxt;
  logic [31:0]            rng_r, rng_nxt;
  logic [RND_W-1:0]       cnt_r, cnt_nxt;
  logic [POP_W-1:0]       n_r, n_nxt;
  logic                   v1_r, v1_nxt;
  logic                   v2_r;
  logic [IDX_W-1:0]       slot2_r;
  logic [FIT_W-1:0]       best_r, best_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic                   found_r, found_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [WIN_W-1:0]       out_idx_r;
  logic [FIT_W-1:0]       out_fit_r;
  logic                   out_found_r;
  logic                   out_load;
  logic                   ram_we;
  logic [31+POP_W:0]      prod;
  logic [IDX_W-1:0]       slot;
  logic [FIT_W-1:0]       rdata;

  // draw scaling: high bits of state times population
  assign prod = {{POP_W{1'b0}}, rng_r} * {{32{1'b0}}, n_r};
  assign slot = prod[32 +: IDX_W];

  lts_ram #(
    .WIDTH (FIT_W),
    .DEPTH (POP_MAX)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.idx),
    .wdata (head.data),
    .raddr (slot),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    rng_nxt      = rng_r;
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    v1_nxt       = 1'b0;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    found_nxt    = found_r;
    pop          = 1'b0;
    ram_we       = 1'b0;
    out_load     = 1'b0;

    if (v2_r && ($signed(rdata) > $signed(best_r))) begin
      best_nxt     = rdata;
      best_idx_nxt = slot2_r;
      found_nxt    = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          unique case (head.kind)
            K_LOAD: begin
              ram_we = 1'b1;
            end
            K_RESEED: begin
              rng_nxt = head.data;
            end
            K_TOUR: begin
              n_nxt     = cfg.n;
              cnt_nxt   = cfg.r;
              best_nxt  = MINUS_INF;
              found_nxt = 1'b0;
              state_nxt = (cfg.r == '0) ? ST_DONE : ST_RUN;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_RUN: begin
        rng_nxt = 32'(rng_r * LCG_MUL + LCG_ADD);
        v1_nxt  = 1'b1;
        cnt_nxt = RND_W'(cnt_r - 1'b1);
        if (cnt_r == RND_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last compare lands at this edge
        if (v2_r && !v1_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rng_r       <= RNG_RESET;
      cnt_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rng_r       <= rng_nxt;
      cnt_r       <= cnt_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    found_r    <= found_nxt;
    if (v1_r) begin
      slot2_r <= slot;
    end
    if (out_load) begin
      out_idx_r   <= found_r ? WIN_W'(best_idx_r) : '0;
      out_fit_r   <= best_r;
      out_found_r <= found_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.winner_index   = out_idx_r;
  assign out_ch.winner_fitness = out_fit_r;
  assign out_ch.found          = out_found_r;

  assign stat.state = state_r;
  assign stat.cnt   = cnt_r;

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for lcg_tournament_selector_top, a directed table then random phases
// predicts each untyped tournament from its own copy of the generator, table and registers
// depends on lts_pkg and lts_ifs

module tb import lts_pkg::*; ();

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [FIT_W-1:0] FIT_TOP = 32'h7fffffff;
  localparam int SETTLE_CYCLES = 2 * (ROUNDS_MAX + 4) + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 250;
  localparam int PLAN_LEN = 27;

  typedef struct packed {
    logic [WIN_W-1:0] idx;
    logic [FIT_W-1:0] fit;
    logic             found;
  } winner_t;

  typedef struct packed {
    bit                    cfg_row;
    lts_cfg_idx_e          reg_sel;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [CMD_W-1:0]      cmd;
    logic [ENTRY_W-1:0]    entry;
    logic [FIT_W-1:0]      fit;
    logic [SEED_W-1:0]     seed;
    bit                    typed;
    winner_t               want;
  } step_t;

  logic clk;
  logic rst_n;

  lts_in_if  in_ch();
  lts_out_if out_ch();
  lts_cfg_if cfg_ch();

  lcg_tournament_selector_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the block
  logic [31:0]        gen_state = RNG_RESET;
  logic [FIT_W-1:0]   fit_table [POP_MAX];
  bit                 written [POP_MAX];
  logic [POP_CFG_W-1:0] pop_reg = 9'd256;
  logic [RND_CFG_W-1:0] rounds_reg = 5'd3;

  winner_t winners_due [$];
  int      n_errors = 0;
  int      quiet_cycles = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;

  step_t plan [PLAN_LEN] = '{
    '{1'b1, CFG_POP_COUNT, 16'hfe01, CMD_LOAD, '0, '0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_LOAD, 8'd0, FIT_TOP, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_TOUR, '0, '0, '0, 1'b1, '{8'd0, FIT_TOP, 1'b1}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_LOAD, 8'd0, MINUS_INF, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_TOUR, '0, '0, '0, 1'b1, '{8'd0, MINUS_INF, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_LOAD, 8'd0, 32'h80000001, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_TOUR, '0, '0, '0, 1'b1, '{8'd0, 32'h80000001, 1'b1}},
    '{1'b1, CFG_ROUNDS, 16'h0000, CMD_LOAD, '0, '0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_TOUR, '0, '0, '0, 1'b1, '{8'd0, MINUS_INF, 1'b0}},
    '{1'b1, CFG_ROUNDS, 16'hffff, CMD_LOAD, '0, '0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_LOAD, 8'd0, 32'h0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_TOUR, '0, '0, '0, 1'b1, '{8'd0, 32'h0, 1'b1}},
    '{1'b1, CFG_POP_COUNT, 16'h0000, CMD_LOAD, '0, '0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_LOAD, 8'd0, 32'hffffffff, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_TOUR, '0, '0, '0, 1'b1, '{8'd0, 32'hffffffff, 1'b1}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_UNUSED, 8'hff, 32'hffffffff, 32'hffffffff, 1'b0,
      '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_TOUR, '0, '0, '0, 1'b1, '{8'd0, 32'hffffffff, 1'b1}},
    '{1'b1, CFG_POP_COUNT, 16'h0002, CMD_LOAD, '0, '0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_LOAD, 8'd1, 32'hffffffff, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_RESEED, '0, '0, 32'h0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_TOUR, '0, '0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_RESEED, '0, '0, 32'hffffffff, 1'b0, '{'0, '0, 1'b0}},
    '{1'b1, CFG_ROUNDS, 16'h0001, CMD_LOAD, '0, '0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b1, CFG_POP_COUNT, 16'h01ff, CMD_LOAD, '0, '0, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_LOAD, 8'd255, FIT_TOP, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_LOAD, 8'd60, 32'h12345678, '0, 1'b0, '{'0, '0, 1'b0}},
    '{1'b0, CFG_POP_COUNT, '0, CMD_TOUR, '0, '0, '0, 1'b0, '{'0, '0, 1'b0}}
  };

  function automatic logic [31:0] lcg_step(logic [31:0] st);
    return st * LCG_MUL + LCG_ADD;
  endfunction

  // high bits of state times population, population saturated at the table size
  function automatic logic [IDX_W-1:0] draw_slot(logic [31:0] st);
    logic [63:0] prod;
    int          n;
    n = (pop_reg > POP_MAX) ? POP_MAX : int'(pop_reg);
    prod = 64'(st) * 64'(n);
    return prod[32 +: IDX_W];
  endfunction

  function automatic int eff_rounds();
    return (rounds_reg > ROUNDS_MAX) ? ROUNDS_MAX : int'(rounds_reg);
  endfunction

  function automatic logic [FIT_W-1:0] rand_fit();
    case ($urandom_range(7))
      0: return MINUS_INF;
      1: return FIT_TOP;
      2: return 32'h80000001;
      3, 4: return 32'((int'($urandom_range(4)) - 2) * 65536);
      default: return $urandom;
    endcase
  endfunction

  // drive one word, then update the shadow and queue the tournament outcome
  task automatic issue_word(input logic [CMD_W-1:0] cmd, input logic [ENTRY_W-1:0] entry,
                            input logic [FIT_W-1:0] fit, input logic [SEED_W-1:0] seed,
                            input bit typed, input winner_t want);
    winner_t          res;
    logic [IDX_W-1:0] s;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.entry_index   <= entry;
    in_ch.fitness_value <= fit;
    in_ch.seed_value    <= seed;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    case (cmd)
      CMD_LOAD: begin
        fit_table[entry] = fit;
        written[entry] = 1'b1;
      end
      CMD_RESEED: gen_state = seed;
      CMD_TOUR: begin
        res = '0;
        res.fit = MINUS_INF;
        for (int k = 0; k < eff_rounds(); k++) begin
          gen_state = lcg_step(gen_state);
          s = draw_slot(gen_state);
          // strictly greater only, so an equal later draw keeps the earlier winner
          if ($signed(fit_table[s]) > $signed(res.fit)) begin
            res.fit = fit_table[s];
            res.idx = s;
            res.found = 1'b1;
          end
        end
        winners_due.push_back(typed ? want : res);
      end
      default: ;
    endcase
  endtask

  // a tournament never draws a slot that was never loaded: load those first
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ENTRY_W-1:0] entry,
                           input logic [FIT_W-1:0] fit, input logic [SEED_W-1:0] seed,
                           input bit typed, input winner_t want);
    logic [31:0]      st;
    logic [IDX_W-1:0] s;
    if (cmd == CMD_TOUR) begin
      st = gen_state;
      for (int k = 0; k < eff_rounds(); k++) begin
        st = lcg_step(st);
        s = draw_slot(st);
        if (!written[s])
          issue_word(CMD_LOAD, s, rand_fit(), $urandom, 1'b0, '0);
      end
    end
    issue_word(cmd, entry, fit, seed, typed, want);
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (winners_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input lts_cfg_idx_e sel, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (sel)
      CFG_POP_COUNT: pop_reg = val[POP_CFG_W-1:0];
      CFG_ROUNDS:    rounds_reg = val[RND_CFG_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin : result_check
    winner_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (winners_due.size() == 0) begin
        n_errors++;
        $error("result word with no tournament outstanding");
      end else begin
        want = winners_due.pop_front();
        if (out_ch.winner_index !== want.idx) begin
          n_errors++;
          $error("winner_index: expected %0d, got %0d", want.idx, out_ch.winner_index);
        end
        if (out_ch.winner_fitness !== want.fit) begin
          n_errors++;
          $error("winner_fitness: expected %0d, got %0d", $signed(want.fit),
                 out_ch.winner_fitness);
        end
        if (out_ch.found !== want.found) begin
          n_errors++;
          $error("found: expected %0d, got %0d", want.found, out_ch.found);
        end
      end
    end
    out_ch.ready <= (rst_n === 1'b1) && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [POP_CFG_W-1:0] pop_sel;
    logic [RND_CFG_W-1:0] rnd_sel;
    logic [CMD_W-1:0]     cmd;
    logic [SEED_W-1:0]    seed;
    int                   pick;
    int                   done_words;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_LOAD;
    in_ch.entry_index   = '0;
    in_ch.fitness_value = '0;
    in_ch.seed_value    = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_POP_COUNT;
    cfg_ch.data         = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg_row) begin
        wait_for_results();
        write_reg(plan[i].reg_sel, plan[i].reg_data);
      end else begin
        send_word(plan[i].cmd, plan[i].entry, plan[i].fit, plan[i].seed, plan[i].typed,
                  plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin pop_sel = 9'd256; rnd_sel = 5'd3; end
        1: begin pop_sel = 9'd1; rnd_sel = 5'd16; end
        2: begin pop_sel = 9'h1ff; rnd_sel = 5'h1f; end
        3: begin pop_sel = 9'd0; rnd_sel = 5'd1; end
        5: begin pop_sel = 9'd2; rnd_sel = 5'd0; end
        default: begin
          pop_sel = 9'($urandom_range(3, 255));
          rnd_sel = 5'($urandom_range(2, 15));
        end
      endcase
      wait_for_results();
      write_reg(CFG_POP_COUNT, {7'($urandom), pop_sel});
      write_reg(CFG_ROUNDS, {11'($urandom), rnd_sel});
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 67; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 67; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      done_words = 0;
      while (done_words < WORDS_PER_PHASE) begin
        if ($urandom_range(199) == 0)
          wait_for_results();
        pick = $urandom_range(99);
        if (pick < 50)
          cmd = CMD_TOUR;
        else if (pick < 82)
          cmd = CMD_LOAD;
        else if (pick < 95)
          cmd = CMD_RESEED;
        else
          cmd = CMD_UNUSED;
        case ($urandom_range(9))
          0: seed = '0;
          1: seed = '1;
          default: seed = $urandom;
        endcase
        send_word(cmd, 8'($urandom), rand_fit(), seed, 1'b0, '0);
        if (cmd != CMD_UNUSED)
          done_words++;
      end
    end

    wait_for_results();
    if (n_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
